// ===== hdl/slt_pkg.sv =====
// Shared constants and field widths for the sorted list table.
package slt_pkg;

    // Field widths of one transaction on each side.
    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned POS_W      = 7;
    localparam int unsigned OP_W       = 2;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned S_TDATA_W  = 40;
    localparam int unsigned M_TDATA_W  = 16;

    // Operation codes carried on the slave tuser.
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    // Result status codes carried on the master tuser.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_POS   = 2'd3;

endpackage

// ===== hdl/slt_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module slt_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/sorted_list_table_unit.sv =====
// Sorted list table: ascending signed table with search, insert and delete.
//
// Usage: one command transaction enters on the slave stream; tuser holds the
// opcode (search, insert, delete) and tdata holds the value and the one-based
// position. Exactly one result transaction leaves on the master stream for
// each command: tuser holds the status, tdata the found or inserted position
// and the entry count after the operation.
// The entries live in one RAM with a registered read; all work is a
// read-modify-write walk through that RAM, one command at a time.
// Flow from acceptance to a result: search probes the table by binary search,
// one read and one compare per probe; insert walks down from the last entry,
// moving each larger entry up one place; delete walks up from the deleted
// position, moving each later entry down one place; a full table, a bad
// position or an unused opcode goes straight to the result.
// The RAM port streams one entry a cycle during insert and delete, so the
// work of a command grows with the number of entries that it moves.
// Reset clears the entry count and the output valid flag; the RAM contents are
// not cleared, since entries beyond the count are never used.
// When the receiver stalls, the finished result waits in the output register
// and the next command is still accepted and worked on; only its own result
// waits until the register frees up.
module sorted_list_table_unit #(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Slave command stream.
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // tdata: value [31:0], position [38:32], zero [39]
    input  logic [slt_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    // tuser: opcode [1:0]
    input  logic [slt_pkg::OP_W-1:0]        i_s_axis_tuser,
    // Master result stream.
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // tdata: found_position [6:0], entry_count [13:7], zero [15:14]
    output logic [slt_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,
    // tuser: status [1:0]
    output logic [slt_pkg::STATUS_W-1:0]    o_m_axis_tuser
);

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned IW = ((CW > slt_pkg::POS_W) ? CW : slt_pkg::POS_W) + 1;
    localparam int unsigned VW = slt_pkg::VALUE_W;
    localparam int unsigned PW = slt_pkg::POS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_INS_CMP,
        S_DEL_MV,
        S_RESP
    } t_state;

    t_state r_state, n_state;

    logic [VW-1:0]                  r_value, n_value;
    logic [IW-1:0]                  r_lo, n_lo;
    logic [IW-1:0]                  r_hi, n_hi;
    logic [IW-1:0]                  r_idx, n_idx;
    logic [CW-1:0]                  r_count, n_count;
    logic [slt_pkg::STATUS_W-1:0]   r_res_status, n_res_status;
    logic [IW-1:0]                  r_res_pos, n_res_pos;
    logic                           r_m_valid, n_m_valid;
    logic [slt_pkg::STATUS_W-1:0]   r_m_status, n_m_status;
    logic [PW-1:0]                  r_m_pos, n_m_pos;
    logic [PW-1:0]                  r_m_count, n_m_count;

    logic                           s_accept;
    logic [IW-1:0]                  cnt_ext;
    logic [IW-1:0]                  in_pos;
    logic [IW:0]                    mid_sum;
    logic [IW-1:0]                  mid;

    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic [VW-1:0]                  ram_wdata;
    logic                           ram_re;
    logic [AW-1:0]                  ram_raddr;
    logic [VW-1:0]                  ram_rdata;

    slt_ram #(
        .WIDTH(VW),
        .DEPTH(TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign cnt_ext         = IW'(r_count);
    assign in_pos          = IW'(i_s_axis_tdata[VW +: PW]);
    assign mid_sum         = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid             = mid_sum[IW:1];

    // Command sequencer: drives the RAM ports and computes next state.
    always_comb begin
        n_state      = r_state;
        n_value      = r_value;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_idx        = r_idx;
        n_count      = r_count;
        n_res_status = r_res_status;
        n_res_pos    = r_res_pos;
        n_m_valid    = r_m_valid && !i_m_axis_tready;
        n_m_status   = r_m_status;
        n_m_pos      = r_m_pos;
        n_m_count    = r_m_count;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = r_value;
        ram_re       = 1'b0;
        ram_raddr    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_value      = i_s_axis_tdata[VW-1:0];
                    n_res_status = slt_pkg::ST_OK;
                    n_res_pos    = '0;
                    unique case (i_s_axis_tuser)
                        slt_pkg::OP_SEARCH: begin
                            n_lo    = IW'(1);
                            n_hi    = cnt_ext;
                            n_state = S_SRCH_RD;
                        end
                        slt_pkg::OP_INSERT: begin
                            if (cnt_ext >= IW'(TABLE_DEPTH)) begin
                                n_res_status = slt_pkg::ST_FULL;
                                n_state      = S_RESP;
                            end else begin
                                // Fetch the last entry to start the shift walk.
                                ram_re    = 1'b1;
                                ram_raddr = AW'(cnt_ext - IW'(1));
                                n_idx     = cnt_ext;
                                n_state   = S_INS_CMP;
                            end
                        end
                        slt_pkg::OP_DELETE: begin
                            if (in_pos == '0 || in_pos > cnt_ext) begin
                                n_res_status = slt_pkg::ST_BAD_POS;
                                n_state      = S_RESP;
                            end else begin
                                // Fetch the entry just above the deleted one.
                                ram_re    = 1'b1;
                                ram_raddr = AW'(in_pos);
                                n_idx     = in_pos;
                                n_state   = S_DEL_MV;
                            end
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end

            S_SRCH_RD: begin
                if (r_lo > r_hi) begin
                    n_res_status = slt_pkg::ST_NOT_FOUND;
                    n_state      = S_RESP;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(mid - IW'(1));
                    n_idx     = mid;
                    n_state   = S_SRCH_CMP;
                end
            end

            S_SRCH_CMP: begin
                if (ram_rdata == r_value) begin
                    n_res_pos = r_idx;
                    n_state   = S_RESP;
                end else begin
                    if ($signed(ram_rdata) > $signed(r_value)) begin
                        n_hi = r_idx - IW'(1);
                    end else begin
                        n_lo = r_idx + IW'(1);
                    end
                    n_state = S_SRCH_RD;
                end
            end

            S_INS_CMP: begin
                if (r_idx != '0 && $signed(r_value) < $signed(ram_rdata)) begin
                    // Move the larger entry up one place and fetch the next one down.
                    ram_we    = 1'b1;
                    ram_waddr = AW'(r_idx);
                    ram_wdata = ram_rdata;
                    ram_re    = 1'b1;
                    ram_raddr = AW'(r_idx - IW'(2));
                    n_idx     = r_idx - IW'(1);
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(r_idx);
                    ram_wdata = r_value;
                    n_res_pos = r_idx + IW'(1);
                    n_count   = CW'(r_count + 1'b1);
                    n_state   = S_RESP;
                end
            end

            S_DEL_MV: begin
                if (r_idx >= cnt_ext) begin
                    n_count = CW'(r_count - 1'b1);
                    n_state = S_RESP;
                end else begin
                    // Move the fetched entry down one place and fetch the next one up.
                    ram_we    = 1'b1;
                    ram_waddr = AW'(r_idx - IW'(1));
                    ram_wdata = ram_rdata;
                    ram_re    = 1'b1;
                    ram_raddr = AW'(r_idx + IW'(1));
                    n_idx     = r_idx + IW'(1);
                end
            end

            S_RESP: begin
                // Hand the result to the output register once it is free.
                if (!r_m_valid || i_m_axis_tready) begin
                    n_m_valid  = 1'b1;
                    n_m_status = r_res_status;
                    n_m_pos    = r_res_pos[PW-1:0];
                    n_m_count  = cnt_ext[PW-1:0];
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, count and output valid flag; payload registers take no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_m_valid <= n_m_valid;
        end
        r_value      <= n_value;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_idx        <= n_idx;
        r_res_status <= n_res_status;
        r_res_pos    <= n_res_pos;
        r_m_status   <= n_m_status;
        r_m_pos      <= n_m_pos;
        r_m_count    <= n_m_count;
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {2'b00, r_m_count, r_m_pos};
    assign o_m_axis_tuser  = r_m_status;

endmodule

// ===== hdl/slt_checker.sv =====
// Port-level checks for the sorted list table, bound to the top level.
module slt_checker #(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [slt_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,
    input logic [slt_pkg::STATUS_W-1:0]    o_m_axis_tuser
);

    // No result is offered right after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // A stalled result holds its contents.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    // Commands are processed one at a time: no acceptance in the next cycle.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("command accepted while another is in progress");

    // Failed operations report no position.
    a_fail_no_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != slt_pkg::ST_OK |->
            o_m_axis_tdata[6:0] == 7'd0)
        else $error("position reported with a failing status");

    // The count never exceeds the table capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (TABLE_DEPTH > 127) || (32'(o_m_axis_tdata[13:7]) <= TABLE_DEPTH))
        else $error("entry count above capacity");

endmodule

bind sorted_list_table_unit slt_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_slt_checker (.*);
